[hw/rtl/gamepad_delta_frame_encoder_defines.svh]
// ----------------------------------------------------------------------------
// gamepad delta frame encoder assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_DELTA_FRAME_ENCODER_DEFINES_SVH
`define GAMEPAD_DELTA_FRAME_ENCODER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define GDFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdfe assertion failed");

// consequent holds in the cycle after the antecedent
`define GDFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdfe assertion failed");

`endif

[hw/rtl/gdfe_pkg.sv]
// ----------------------------------------------------------------------------
// gdfe_pkg
// types and constants shared by the gamepad delta frame encoder modules
// ----------------------------------------------------------------------------
package gdfe_pkg;

  // frames buffered between classifier and serializer
  localparam int QUEUE_DEPTH = 2;

  localparam int ANALOG_COUNT = 6;
  localparam int SLOT_COUNT   = 8;

  // header bit of each group
  localparam int GRP_LT   = 0;
  localparam int GRP_RT   = 1;
  localparam int GRP_LS   = 2;
  localparam int GRP_RS   = 3;
  localparam int GRP_AC   = 4;
  localparam int GRP_MISC = 5;

  typedef struct packed {
    logic [5:0] hdr;
    logic [7:0] left_trigger;
    logic [7:0] right_trigger;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] arrow_color_buttons;
    logic [6:0] misc_buttons;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/gdfe_in_if.sv]
// ----------------------------------------------------------------------------
// gdfe_in_if
// snapshot channel: valid/ready handshake with the gamepad fields
// ----------------------------------------------------------------------------
interface gdfe_in_if;
  logic       valid;
  logic       ready;
  logic       keyframe;
  logic [7:0] left_trigger;
  logic [7:0] right_trigger;
  logic [7:0] left_stick_x;
  logic [7:0] left_stick_y;
  logic [7:0] right_stick_x;
  logic [7:0] right_stick_y;
  logic [7:0] arrow_color_buttons;
  logic [6:0] misc_buttons;

  modport source (
    output valid, keyframe, left_trigger, right_trigger, left_stick_x, left_stick_y,
           right_stick_x, right_stick_y, arrow_color_buttons, misc_buttons,
    input  ready
  );

  modport sink (
    input  valid, keyframe, left_trigger, right_trigger, left_stick_x, left_stick_y,
           right_stick_x, right_stick_y, arrow_color_buttons, misc_buttons,
    output ready
  );
endinterface

[hw/rtl/gdfe_out_if.sv]
// ----------------------------------------------------------------------------
// gdfe_out_if
// frame byte channel: valid/ready handshake with byte and end marker
// ----------------------------------------------------------------------------
interface gdfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

[hw/rtl/gdfe_front.sv]
// ----------------------------------------------------------------------------
// gdfe_front
// accepts snapshots, flags changed groups against the stored snapshot
// ----------------------------------------------------------------------------
module gdfe_front (
  input  logic              clk,
  input  logic              rst_n,
  gdfe_in_if.sink           in_if,
  input  gdfe_pkg::q_stat_t q_stat,
  output logic              push,
  output gdfe_pkg::frame_t  push_data
);

  logic [7:0] cur [gdfe_pkg::ANALOG_COUNT];
  logic [7:0] prev_analog_r [gdfe_pkg::ANALOG_COUNT];
  logic [7:0] prev_arrow_color_r;
  logic [6:0] prev_misc_r;
  logic [5:0] hdr;
  logic       acc;
  logic       key;

  assign in_if.ready = !q_stat.full;
  assign acc         = in_if.valid && in_if.ready;
  assign key         = in_if.keyframe;

  assign cur[0] = in_if.left_trigger;
  assign cur[1] = in_if.right_trigger;
  assign cur[2] = in_if.left_stick_x;
  assign cur[3] = in_if.left_stick_y;
  assign cur[4] = in_if.right_stick_x;
  assign cur[5] = in_if.right_stick_y;

  always_comb begin
    hdr                     = '0;
    hdr[gdfe_pkg::GRP_LT]   = key || (cur[0] != prev_analog_r[0]);
    hdr[gdfe_pkg::GRP_RT]   = key || (cur[1] != prev_analog_r[1]);
    // either axis moving sends the whole stick
    hdr[gdfe_pkg::GRP_LS]   = key || (cur[2] != prev_analog_r[2])
                                  || (cur[3] != prev_analog_r[3]);
    hdr[gdfe_pkg::GRP_RS]   = key || (cur[4] != prev_analog_r[4])
                                  || (cur[5] != prev_analog_r[5]);
    hdr[gdfe_pkg::GRP_AC]   = key || (in_if.arrow_color_buttons != prev_arrow_color_r);
    hdr[gdfe_pkg::GRP_MISC] = key || (in_if.misc_buttons != prev_misc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gdfe_pkg::ANALOG_COUNT; i++) prev_analog_r[i] <= '0;
      prev_arrow_color_r <= '0;
      prev_misc_r        <= '0;
    end else if (acc) begin
      for (int i = 0; i < gdfe_pkg::ANALOG_COUNT; i++) prev_analog_r[i] <= cur[i];
      prev_arrow_color_r <= in_if.arrow_color_buttons;
      prev_misc_r        <= in_if.misc_buttons;
    end
  end

  assign push = acc;

  always_comb begin
    push_data.hdr                 = hdr;
    push_data.left_trigger        = cur[0];
    push_data.right_trigger       = cur[1];
    push_data.left_stick_x        = cur[2];
    push_data.left_stick_y        = cur[3];
    push_data.right_stick_x       = cur[4];
    push_data.right_stick_y       = cur[5];
    push_data.arrow_color_buttons = in_if.arrow_color_buttons;
    push_data.misc_buttons        = in_if.misc_buttons;
  end

endmodule

[hw/rtl/gdfe_queue.sv]
// ----------------------------------------------------------------------------
// gdfe_queue
// small frame queue between classifier and serializer
// ----------------------------------------------------------------------------
module gdfe_queue #(
  parameter int DEPTH = gdfe_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gdfe_pkg::frame_t  push_data,
  input  logic              pop,
  output gdfe_pkg::frame_t  pop_data,
  output gdfe_pkg::q_stat_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gdfe_pkg::frame_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

[hw/rtl/gdfe_back.sv]
// ----------------------------------------------------------------------------
// gdfe_back
// serializes a queued frame: header byte, then each flagged group's bytes
// ----------------------------------------------------------------------------
module gdfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gdfe_pkg::q_stat_t q_stat,
  input  gdfe_pkg::frame_t  pop_data,
  output logic              pop,
  gdfe_out_if.source        out_if
);

  localparam int SC = gdfe_pkg::SLOT_COUNT;

  gdfe_pkg::frame_t frame_r;
  logic          hdr_pend_r;
  logic [SC-1:0] rem_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic [7:0]    slot_byte [SC];
  logic [SC-1:0] lsb, rem_clr, load_mask;
  logic [7:0]    sel, emit_byte;
  logic          adv, have, emit, emit_last, load;

  assign slot_byte[0] = frame_r.left_trigger;
  assign slot_byte[1] = frame_r.right_trigger;
  assign slot_byte[2] = frame_r.left_stick_x;
  assign slot_byte[3] = frame_r.left_stick_y;
  assign slot_byte[4] = frame_r.right_stick_x;
  assign slot_byte[5] = frame_r.right_stick_y;
  assign slot_byte[6] = frame_r.arrow_color_buttons;
  assign slot_byte[7] = {1'b0, frame_r.misc_buttons};

  // stick groups cover two byte slots each
  assign load_mask = {pop_data.hdr[gdfe_pkg::GRP_MISC], pop_data.hdr[gdfe_pkg::GRP_AC],
                      pop_data.hdr[gdfe_pkg::GRP_RS],   pop_data.hdr[gdfe_pkg::GRP_RS],
                      pop_data.hdr[gdfe_pkg::GRP_LS],   pop_data.hdr[gdfe_pkg::GRP_LS],
                      pop_data.hdr[gdfe_pkg::GRP_RT],   pop_data.hdr[gdfe_pkg::GRP_LT]};

  // next slot is the lowest pending one
  assign lsb     = rem_r & (~rem_r + 1'b1);
  assign rem_clr = rem_r & (rem_r - 1'b1);

  always_comb begin
    sel = '0;
    for (int i = 0; i < SC; i++) begin
      if (lsb[i]) sel = sel | slot_byte[i];
    end
  end

  assign adv       = !out_valid_r || out_if.ready;
  assign have      = hdr_pend_r || (rem_r != '0);
  assign emit      = adv && have;
  assign emit_byte = hdr_pend_r ? {2'b00, frame_r.hdr} : sel;
  assign emit_last = hdr_pend_r ? (rem_r == '0) : (rem_clr == '0);
  // take the next frame while the last byte of this one goes out
  assign load      = !q_stat.empty && (!have || (emit && emit_last));
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pend_r  <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= have;
      if (load) begin
        hdr_pend_r <= 1'b1;
        rem_r      <= load_mask;
      end else if (emit) begin
        if (hdr_pend_r) hdr_pend_r <= 1'b0;
        else            rem_r      <= rem_clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) frame_r <= pop_data;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.last_byte = out_last_r;

endmodule

[hw/rtl/gamepad_delta_frame_encoder.sv]
// ----------------------------------------------------------------------------
// gamepad_delta_frame_encoder
// one snapshot in, one delta update frame out as a byte stream
// ----------------------------------------------------------------------------
// Each accepted snapshot becomes a frame of 1 to 9 bytes: a header whose bits
// 0 to 5 flag the changed groups, then those groups' bytes in fixed order,
// with last_byte high on the final byte. The output port moves one byte a
// cycle while out_if.ready is high; a keyframe has all 9 bytes. The next queued
// frame is taken as the last byte of the one before goes out. Snapshots are
// classified on arrival and held in a frame queue of QUEUE_DEPTH entries, so the
// input stays ready until that queue fills. The stored snapshot resets to zeros.
`include "gamepad_delta_frame_encoder_defines.svh"

module gamepad_delta_frame_encoder #(
  parameter int QUEUE_DEPTH = gdfe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  gdfe_in_if.sink    in_if,
  gdfe_out_if.source out_if
);

  gdfe_pkg::q_stat_t q_stat;
  gdfe_pkg::frame_t  push_data;
  gdfe_pkg::frame_t  pop_data;
  logic              push;
  logic              pop;

  gdfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  gdfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  gdfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_if   (out_if)
  );

  `GDFE_ASSERT_IMPL(a_pop_has_frame, pop, !q_stat.empty)
  `GDFE_ASSERT_IMPL(a_push_has_room, push, !q_stat.full)
  `GDFE_ASSERT_NEXT(a_push_not_empty, push && !pop, !q_stat.empty)

endmodule
